### rtl/core/lpi_pkg.sv
// Shared constants and types of the line / plane intersection core.
package lpi_pkg;

    localparam int OUT_BITS     = 32;
    localparam int QUO_BITS     = 32;
    localparam int CFG_IDX_BITS = 2;
    localparam int LANE_STAGES  = QUO_BITS + 5;

    localparam logic signed [OUT_BITS-1:0] OUT_MAX = {1'b0, {(OUT_BITS-1){1'b1}}};
    localparam logic signed [OUT_BITS-1:0] OUT_MIN = {1'b1, {(OUT_BITS-1){1'b0}}};

    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_POINT_A = 2'd0,
        REG_POINT_B = 2'd1,
        REG_POINT_C = 2'd2,
        REG_MIN_DEN = 2'd3
    } cfg_reg_t;

endpackage

### rtl/core/lpi_if.sv
// Handshake interfaces for the line words in and the intersection words out.
interface lpi_ray_if #(parameter int COORD_BITS = 16);
    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] start_x;
    logic signed [COORD_BITS-1:0] start_y;
    logic signed [COORD_BITS-1:0] start_z;
    logic signed [COORD_BITS-1:0] end_x;
    logic signed [COORD_BITS-1:0] end_y;
    logic signed [COORD_BITS-1:0] end_z;

    modport source (output valid, start_x, start_y, start_z, end_x, end_y, end_z,
                    input ready);
    modport sink (input valid, start_x, start_y, start_z, end_x, end_y, end_z,
                  output ready);
endinterface

interface lpi_hit_if;
    logic                                valid;
    logic                                ready;
    logic                                hit;
    logic signed [lpi_pkg::OUT_BITS-1:0] inter_x;
    logic signed [lpi_pkg::OUT_BITS-1:0] inter_y;
    logic signed [lpi_pkg::OUT_BITS-1:0] inter_z;
    logic                                clipped;

    modport source (output valid, hit, inter_x, inter_y, inter_z, clipped, input ready);
    modport sink (input valid, hit, inter_x, inter_y, inter_z, clipped, output ready);
endinterface

### rtl/core/lpi_front.sv
// Front pipeline: plane normal, denominator and numerator dot products.
module lpi_front #(
    parameter int COORD_BITS = 16
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           en,
    input  logic                           in_valid,
    input  logic signed [COORD_BITS-1:0]   start_pt [3],
    input  logic signed [COORD_BITS-1:0]   end_pt [3],
    input  logic [3*COORD_BITS-1:0]        point_a,
    input  logic [3*COORD_BITS-1:0]        point_b,
    input  logic [3*COORD_BITS-1:0]        point_c,
    output logic                           out_valid,
    output logic signed [3*COORD_BITS+5:0] den,
    output logic signed [3*COORD_BITS+5:0] num,
    output logic signed [COORD_BITS:0]     delta [3],
    output logic signed [COORD_BITS-1:0]   start_o [3]
);
    localparam int DIF = COORD_BITS + 1;
    localparam int CRS = 2*COORD_BITS + 2;
    localparam int NRM = 2*COORD_BITS + 3;
    localparam int DOT = 3*COORD_BITS + 4;
    localparam int SUM = 3*COORD_BITS + 6;

    logic signed [COORD_BITS-1:0] pa [3];
    logic signed [COORD_BITS-1:0] pb [3];
    logic signed [COORD_BITS-1:0] pc [3];

    logic [4:0] vld_reg;

    logic signed [DIF-1:0]        v1_reg [3];
    logic signed [DIF-1:0]        v2_reg [3];
    logic signed [DIF-1:0]        dl1_reg [3];
    logic signed [DIF-1:0]        as1_reg [3];
    logic signed [COORD_BITS-1:0] s1_reg [3];

    logic signed [CRS-1:0]        cr_reg [6];
    logic signed [DIF-1:0]        dl2_reg [3];
    logic signed [DIF-1:0]        as2_reg [3];
    logic signed [COORD_BITS-1:0] s2_reg [3];

    logic signed [NRM-1:0]        n_reg [3];
    logic signed [DIF-1:0]        dl3_reg [3];
    logic signed [DIF-1:0]        as3_reg [3];
    logic signed [COORD_BITS-1:0] s3_reg [3];

    logic signed [DOT-1:0]        dp_reg [3];
    logic signed [DOT-1:0]        mp_reg [3];
    logic signed [DIF-1:0]        dl4_reg [3];
    logic signed [COORD_BITS-1:0] s4_reg [3];

    logic signed [SUM-1:0]        den_reg;
    logic signed [SUM-1:0]        num_reg;
    logic signed [DIF-1:0]        dl5_reg [3];
    logic signed [COORD_BITS-1:0] s5_reg [3];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            pa[i] = $signed(point_a[i*COORD_BITS +: COORD_BITS]);
            pb[i] = $signed(point_b[i*COORD_BITS +: COORD_BITS]);
            pc[i] = $signed(point_c[i*COORD_BITS +: COORD_BITS]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[3:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                v1_reg[i]  <= DIF'(pc[i]) - DIF'(pa[i]);
                v2_reg[i]  <= DIF'(pb[i]) - DIF'(pa[i]);
                dl1_reg[i] <= DIF'(end_pt[i]) - DIF'(start_pt[i]);
                as1_reg[i] <= DIF'(pa[i]) - DIF'(start_pt[i]);
                s1_reg[i]  <= start_pt[i];

                dl2_reg[i] <= dl1_reg[i];
                as2_reg[i] <= as1_reg[i];
                s2_reg[i]  <= s1_reg[i];

                n_reg[i]   <= NRM'(cr_reg[2*i]) - NRM'(cr_reg[2*i+1]);
                dl3_reg[i] <= dl2_reg[i];
                as3_reg[i] <= as2_reg[i];
                s3_reg[i]  <= s2_reg[i];

                dp_reg[i]  <= DOT'(n_reg[i]) * DOT'(dl3_reg[i]);
                mp_reg[i]  <= DOT'(n_reg[i]) * DOT'(as3_reg[i]);
                dl4_reg[i] <= dl3_reg[i];
                s4_reg[i]  <= s3_reg[i];

                dl5_reg[i] <= dl4_reg[i];
                s5_reg[i]  <= s4_reg[i];
            end
            // Cross product terms of N = (C-A) x (B-A), paired for subtraction.
            cr_reg[0] <= CRS'(v1_reg[1]) * CRS'(v2_reg[2]);
            cr_reg[1] <= CRS'(v1_reg[2]) * CRS'(v2_reg[1]);
            cr_reg[2] <= CRS'(v1_reg[2]) * CRS'(v2_reg[0]);
            cr_reg[3] <= CRS'(v1_reg[0]) * CRS'(v2_reg[2]);
            cr_reg[4] <= CRS'(v1_reg[0]) * CRS'(v2_reg[1]);
            cr_reg[5] <= CRS'(v1_reg[1]) * CRS'(v2_reg[0]);

            den_reg <= SUM'(dp_reg[0]) + SUM'(dp_reg[1]) + SUM'(dp_reg[2]);
            num_reg <= SUM'(mp_reg[0]) + SUM'(mp_reg[1]) + SUM'(mp_reg[2]);
        end
    end

    assign out_valid = vld_reg[4];
    assign den       = den_reg;
    assign num       = num_reg;
    assign delta     = dl5_reg;
    assign start_o   = s5_reg;

endmodule

### rtl/core/lpi_lane.sv
// One coordinate lane: scaled product, restoring divider pipeline, saturation.
module lpi_lane #(
    parameter int COORD_BITS = 16
) (
    input  logic                                clk,
    input  logic                                en,
    input  logic signed [3*COORD_BITS+5:0]      num,
    input  logic [3*COORD_BITS+5:0]             aden,
    input  logic                                den_neg,
    input  logic signed [COORD_BITS:0]          delta,
    input  logic signed [COORD_BITS-1:0]        start,
    output logic signed [lpi_pkg::OUT_BITS-1:0] val,
    output logic                                clip
);
    import lpi_pkg::*;

    localparam int SUM = 3*COORD_BITS + 6;
    localparam int DIF = COORD_BITS + 1;
    localparam int LO  = SUM / 2;
    localparam int HI  = SUM - LO;
    localparam int LOP = LO + 1 + DIF;
    localparam int HIP = HI + DIF;
    localparam int PRD = SUM + DIF;
    localparam int W   = (PRD > SUM + QUO_BITS) ? PRD : SUM + QUO_BITS;
    localparam int SQ  = QUO_BITS + 2;

    logic signed [LOP-1:0]        lo_reg;
    logic signed [HIP-1:0]        hi_reg;
    logic [SUM-1:0]               aden1_reg, aden2_reg, aden3_reg;
    logic                         dneg1_reg, dneg2_reg, neg3_reg;
    logic signed [COORD_BITS-1:0] s1_reg, s2_reg, s3_reg;
    logic signed [PRD-1:0]        p_reg;
    logic [W-1:0]                 rem3_reg;

    logic [W-1:0]                 rem_reg  [QUO_BITS+1];
    logic [QUO_BITS-1:0]          q_reg    [QUO_BITS+1];
    logic [SUM-1:0]               aden_reg [QUO_BITS+1];
    logic                         neg_reg  [QUO_BITS+1];
    logic                         ovf_reg  [QUO_BITS+1];
    logic signed [COORD_BITS-1:0] s_reg    [QUO_BITS+1];

    logic [PRD-1:0]               mag;
    logic signed [SQ-1:0]         sq;
    logic signed [SQ-1:0]         sum;
    logic signed [OUT_BITS-1:0]   val_reg;
    logic                         clip_reg;

    assign mag = p_reg[PRD-1] ? PRD'(-p_reg) : p_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            // Split the numerator so each multiplier stays narrow.
            lo_reg    <= LOP'($signed({1'b0, num[LO-1:0]})) * LOP'(delta);
            hi_reg    <= HIP'($signed(num[SUM-1:LO])) * HIP'(delta);
            aden1_reg <= aden;
            dneg1_reg <= den_neg;
            s1_reg    <= start;

            p_reg     <= (PRD'(hi_reg) <<< LO) + PRD'(lo_reg);
            aden2_reg <= aden1_reg;
            dneg2_reg <= dneg1_reg;
            s2_reg    <= s1_reg;

            rem3_reg  <= W'(mag);
            neg3_reg  <= p_reg[PRD-1] ^ dneg2_reg;
            aden3_reg <= aden2_reg;
            s3_reg    <= s2_reg;

            // A quotient wider than QUO_BITS bits saturates regardless of start.
            ovf_reg[0]  <= rem3_reg >= (W'(aden3_reg) << QUO_BITS);
            rem_reg[0]  <= rem3_reg;
            q_reg[0]    <= '0;
            aden_reg[0] <= aden3_reg;
            neg_reg[0]  <= neg3_reg;
            s_reg[0]    <= s3_reg;
        end
    end

    for (genvar k = 0; k < QUO_BITS; k++)
    begin : g_div
        localparam int B = QUO_BITS - 1 - k;
        logic [W-1:0] shifted;
        logic         ge;

        assign shifted = W'(aden_reg[k]) << B;
        assign ge      = rem_reg[k] >= shifted;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k+1]  <= ge ? rem_reg[k] - shifted : rem_reg[k];
                q_reg[k+1]    <= q_reg[k] | (QUO_BITS'(ge) << B);
                aden_reg[k+1] <= aden_reg[k];
                neg_reg[k+1]  <= neg_reg[k];
                ovf_reg[k+1]  <= ovf_reg[k];
                s_reg[k+1]    <= s_reg[k];
            end
        end
    end

    assign sq  = neg_reg[QUO_BITS] ? -SQ'(q_reg[QUO_BITS]) : SQ'(q_reg[QUO_BITS]);
    assign sum = sq + SQ'(s_reg[QUO_BITS]);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (ovf_reg[QUO_BITS])
            begin
                val_reg  <= neg_reg[QUO_BITS] ? OUT_MIN : OUT_MAX;
                clip_reg <= 1'b1;
            end
            else if (sum > SQ'(OUT_MAX))
            begin
                val_reg  <= OUT_MAX;
                clip_reg <= 1'b1;
            end
            else if (sum < SQ'(OUT_MIN))
            begin
                val_reg  <= OUT_MIN;
                clip_reg <= 1'b1;
            end
            else
            begin
                val_reg  <= sum[OUT_BITS-1:0];
                clip_reg <= 1'b0;
            end
        end
    end

    assign val  = val_reg;
    assign clip = clip_reg;

endmodule

### rtl/core/line_plane_intersection_core.sv
// Top level of the line / plane intersection core.
//
//  channel  | dir | handshake      | word
//  ---------+-----+----------------+-------------------------------------------
//  ray      | in  | valid / ready  | start_x/y/z, end_x/y/z (signed COORD_BITS)
//  result   | out | valid / ready  | hit, inter_x/y/z (signed 32), clipped
//  cfg      | in  | cfg_we         | cfg_index, cfg_wdata
//
// One word is accepted per cycle while the output slot is free. The pipeline has five
// front stages (differences, cross products, normal, products, dot sums) and 37
// per-lane stages, of which 32 are the restoring divider that retires one quotient bit per stage.
// Reset (rst_n low, asynchronous) clears the valid line and loads the plane
// registers with zero and min_denominator with one.
// When the output word is held by the sink, the whole pipeline freezes; no
// word is lost or duplicated, and ready returns as soon as the word is taken.
module line_plane_intersection_core #(
    parameter int COORD_BITS = 16
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    lpi_ray_if.sink                                ray,
    lpi_hit_if.source                              result,
    input  logic                                   cfg_we,
    input  logic [lpi_pkg::CFG_IDX_BITS-1:0]       cfg_index,
    input  logic [((3*COORD_BITS > 32) ? 3*COORD_BITS : 32)-1:0] cfg_wdata
);
    import lpi_pkg::*;

    localparam int PTW  = 3*COORD_BITS;
    localparam int SUM  = 3*COORD_BITS + 6;
    localparam int CMPW = (SUM > 32) ? SUM : 32;

    // Plane configuration.
    logic [PTW-1:0] pa_reg, pb_reg, pc_reg;
    logic [31:0]    min_den_reg;

    // Global advance: the pipeline moves whenever the output slot is free.
    logic en;

    logic signed [COORD_BITS-1:0] start_pt [3];
    logic signed [COORD_BITS-1:0] end_pt [3];

    logic                         front_valid;
    logic signed [SUM-1:0]        den;
    logic signed [SUM-1:0]        num;
    logic signed [COORD_BITS:0]   delta [3];
    logic signed [COORD_BITS-1:0] start_f [3];

    logic [SUM-1:0]               aden;
    logic                         hit_c;

    logic [LANE_STAGES-1:0]       vld_line_reg;
    logic [LANE_STAGES-1:0]       hit_line_reg;

    logic signed [OUT_BITS-1:0]   val_w [3];
    logic                         clip_w [3];
    logic                         out_hit;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pa_reg      <= '0;
            pb_reg      <= '0;
            pc_reg      <= '0;
            min_den_reg <= 32'd1;
        end
        else if (cfg_we)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_POINT_A: pa_reg      <= cfg_wdata[PTW-1:0];
                REG_POINT_B: pb_reg      <= cfg_wdata[PTW-1:0];
                REG_POINT_C: pc_reg      <= cfg_wdata[PTW-1:0];
                REG_MIN_DEN: min_den_reg <= cfg_wdata[31:0];
                default: ;
            endcase
        end
    end

    assign en        = result.ready || !result.valid;
    assign ray.ready = en;

    assign start_pt[0] = ray.start_x;
    assign start_pt[1] = ray.start_y;
    assign start_pt[2] = ray.start_z;
    assign end_pt[0]   = ray.end_x;
    assign end_pt[1]   = ray.end_y;
    assign end_pt[2]   = ray.end_z;

    lpi_front #(.COORD_BITS(COORD_BITS)) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (ray.valid),
        .start_pt (start_pt),
        .end_pt   (end_pt),
        .point_a  (pa_reg),
        .point_b  (pb_reg),
        .point_c  (pc_reg),
        .out_valid(front_valid),
        .den      (den),
        .num      (num),
        .delta    (delta),
        .start_o  (start_f)
    );

    // A zero denominator is never a hit, even with a zero threshold, so the
    // divider never sees a zero divisor on a word that is reported.
    assign aden  = den[SUM-1] ? SUM'(-den) : den;
    assign hit_c = (aden != '0) && (CMPW'(aden) >= CMPW'(min_den_reg));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_line_reg <= '0;
        end
        else if (en)
        begin
            vld_line_reg <= {vld_line_reg[LANE_STAGES-2:0], front_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            hit_line_reg <= {hit_line_reg[LANE_STAGES-2:0], hit_c};
        end
    end

    for (genvar i = 0; i < 3; i++)
    begin : g_lane
        lpi_lane #(.COORD_BITS(COORD_BITS)) u_lane (
            .clk     (clk),
            .en      (en),
            .num     (num),
            .aden    (aden),
            .den_neg (den[SUM-1]),
            .delta   (delta[i]),
            .start   (start_f[i]),
            .val     (val_w[i]),
            .clip    (clip_w[i])
        );
    end

    // A miss reports zero coordinates and no clipping.
    assign out_hit        = hit_line_reg[LANE_STAGES-1];
    assign result.valid   = vld_line_reg[LANE_STAGES-1];
    assign result.hit     = out_hit;
    assign result.inter_x = out_hit ? val_w[0] : '0;
    assign result.inter_y = out_hit ? val_w[1] : '0;
    assign result.inter_z = out_hit ? val_w[2] : '0;
    assign result.clipped = out_hit && (clip_w[0] || clip_w[1] || clip_w[2]);

    // A clipped word has at least one coordinate sitting on a rail.
    assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.clipped |->
            (result.inter_x == OUT_MAX) || (result.inter_x == OUT_MIN) ||
            (result.inter_y == OUT_MAX) || (result.inter_y == OUT_MIN) ||
            (result.inter_z == OUT_MAX) || (result.inter_z == OUT_MIN))
        else $error("clipped word without a saturated coordinate");

    // A miss carries an all-zero payload.
    assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && !result.hit |->
            (result.inter_x == '0) && (result.inter_y == '0) &&
            (result.inter_z == '0) && !result.clipped)
        else $error("miss word with nonzero payload");

    // A held output word freezes the pipeline behind it.
    assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && !result.ready |=> $stable(vld_line_reg))
        else $error("valid line moved while output was stalled");

endmodule

### dv/testbench.sv
// Self-checking testbench of the line / plane intersection core.
`timescale 1ns / 100ps

module testbench;

    import lpi_pkg::*;

    localparam int CB = 16;

    // One line word: start point and end point.
    typedef struct {
        logic signed [CB-1:0] st[3];
        logic signed [CB-1:0] en[3];
    } line_t;

    // One intersection word as it should leave the core.
    typedef struct {
        logic               hit;
        logic signed [31:0] pt[3];
        logic               clipped;
    } crossing_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [CFG_IDX_BITS-1:0] cfg_index;
    logic [47:0] cfg_wdata;

    lpi_ray_if #(.COORD_BITS(CB)) ray_ch ();
    lpi_hit_if hit_ch ();

    line_plane_intersection_core #(.COORD_BITS(CB)) dut (
        .clk(clk),
        .rst_n(rst_n),
        .ray(ray_ch),
        .result(hit_ch),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata)
    );

    // Plane registers as the predictor sees them; they change only while idle.
    logic [47:0] plane_a, plane_b, plane_c;
    logic [31:0] den_floor;

    line_t     lines_to_send[$];
    crossing_t crossings_due[$];
    line_t     line_on_bus;
    int        error_count;
    bit        calm;           // When set, neither side idles.
    bit        hold_req;       // Asks the result side for one long hold-off.
    int        hold_left;

    always
    begin
        clk = 1'b1;
        #10;
        clk = 1'b0;
        #10;
    end

    task automatic report_mismatch(input string what);
        $display("mismatch at %0t: %s", $realtime, what);
        error_count++;
    endtask

    // Exact intersection at 128 bits, then saturation to 32 bits per coordinate.
    function automatic crossing_t predict_crossing(input line_t ln);
        logic signed [127:0] a[3], b[3], c[3], s[3], dl[3], u1[3], u2[3], n[3];
        logic signed [127:0] den, num, aden, v;
        crossing_t r;
        r.hit = 1'b0;
        r.clipped = 1'b0;
        for (int i = 0; i < 3; i++)
        begin
            r.pt[i] = '0;
            a[i] = $signed(plane_a[CB*i +: CB]);
            b[i] = $signed(plane_b[CB*i +: CB]);
            c[i] = $signed(plane_c[CB*i +: CB]);
            s[i] = ln.st[i];
            dl[i] = 128'(ln.en[i]) - 128'(ln.st[i]);
            u1[i] = c[i] - a[i];
            u2[i] = b[i] - a[i];
        end
        // The normal is (C - A) x (B - A).
        n[0] = u1[1] * u2[2] - u1[2] * u2[1];
        n[1] = u1[2] * u2[0] - u1[0] * u2[2];
        n[2] = u1[0] * u2[1] - u1[1] * u2[0];
        den = 0;
        num = 0;
        for (int i = 0; i < 3; i++)
        begin
            den += n[i] * dl[i];
            num += n[i] * (a[i] - s[i]);
        end
        aden = (den < 0) ? -den : den;
        // A zero denominator never counts as a hit, even with a zero floor.
        if (den == 0 || aden < $signed({96'd0, den_floor}))
            return r;
        r.hit = 1'b1;
        for (int i = 0; i < 3; i++)
        begin
            // Signed division in SystemVerilog truncates toward zero.
            v = s[i] + (num * dl[i]) / den;
            if (v > 128'sd2147483647)
            begin
                r.pt[i] = OUT_MAX;
                r.clipped = 1'b1;
            end
            else if (v < -128'sd2147483648)
            begin
                r.pt[i] = OUT_MIN;
                r.clipped = 1'b1;
            end
            else
                r.pt[i] = v[31:0];
        end
        return r;
    endfunction

    // Line driver: valid holds until the word is taken; otherwise it idles at random.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ray_ch.valid <= 1'b0;
        else if (!(ray_ch.valid && !ray_ch.ready))
        begin
            if (ray_ch.valid)
            begin
                crossings_due.push_back(predict_crossing(line_on_bus));
                void'(lines_to_send.pop_front());
            end
            if (lines_to_send.size() != 0 && (calm || $urandom_range(0, 99) >= 31))
            begin
                line_on_bus <= lines_to_send[0];
                ray_ch.start_x <= lines_to_send[0].st[0];
                ray_ch.start_y <= lines_to_send[0].st[1];
                ray_ch.start_z <= lines_to_send[0].st[2];
                ray_ch.end_x <= lines_to_send[0].en[0];
                ray_ch.end_y <= lines_to_send[0].en[1];
                ray_ch.end_z <= lines_to_send[0].en[2];
                ray_ch.valid <= 1'b1;
            end
            else
                ray_ch.valid <= 1'b0;
        end
    end

    // Result side: random stalls, plus one long hold-off so the pipeline backs up.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_ch.ready <= 1'b0;
            hold_left <= 400;
        end
        else if (hold_req && hold_left != 0)
        begin
            hit_ch.ready <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else
            hit_ch.ready <= calm || $urandom_range(0, 99) >= 31;
    end

    // Result monitor: every accepted word is checked against the oldest prediction.
    always @(posedge clk)
    begin
        if (rst_n && hit_ch.valid && hit_ch.ready)
        begin
            if (crossings_due.size() == 0)
                report_mismatch("result word with no line outstanding");
            else
            begin
                crossing_t want;
                want = crossings_due.pop_front();
                if (hit_ch.hit !== want.hit)
                    report_mismatch($sformatf("hit %b, want %b", hit_ch.hit, want.hit));
                if (hit_ch.inter_x !== want.pt[0])
                    report_mismatch($sformatf("inter_x %0d, want %0d",
                                              hit_ch.inter_x, want.pt[0]));
                if (hit_ch.inter_y !== want.pt[1])
                    report_mismatch($sformatf("inter_y %0d, want %0d",
                                              hit_ch.inter_y, want.pt[1]));
                if (hit_ch.inter_z !== want.pt[2])
                    report_mismatch($sformatf("inter_z %0d, want %0d",
                                              hit_ch.inter_z, want.pt[2]));
                if (hit_ch.clipped !== want.clipped)
                    report_mismatch($sformatf("clipped %b, want %b",
                                              hit_ch.clipped, want.clipped));
            end
        end
    end

    function automatic logic [47:0] pack_point(input int x, input int y, input int z);
        return {z[15:0], y[15:0], x[15:0]};
    endfunction

    task automatic queue_line(input int sx, input int sy, input int sz,
                              input int ex, input int ey, input int ez);
        line_t ln;
        ln.st[0] = sx[15:0];
        ln.st[1] = sy[15:0];
        ln.st[2] = sz[15:0];
        ln.en[0] = ex[15:0];
        ln.en[1] = ey[15:0];
        ln.en[2] = ez[15:0];
        lines_to_send.push_back(ln);
    endtask

    task automatic write_reg(input cfg_reg_t idx, input logic [47:0] value);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_POINT_A: plane_a = value;
            REG_POINT_B: plane_b = value;
            REG_POINT_C: plane_c = value;
            REG_MIN_DEN: den_floor = value[31:0];
            default: ;
        endcase
    endtask

    task automatic set_plane(input logic [47:0] a, input logic [47:0] b,
                             input logic [47:0] c, input logic [31:0] floor_value);
        write_reg(REG_POINT_A, a);
        write_reg(REG_POINT_B, b);
        write_reg(REG_POINT_C, c);
        // Bits above the 32-bit floor are junk the core must ignore.
        write_reg(REG_MIN_DEN, {16'($urandom), floor_value});
    endtask

    // Waits until every line has gone out and every word has come back,
    // then lets the pipeline drain fully before touching registers.
    task automatic wait_drained();
        while (lines_to_send.size() != 0 || ray_ch.valid || crossings_due.size() != 0)
            @(posedge clk);
        repeat (60) @(posedge clk);
    endtask

    function automatic int rand_coord(input int span);
        return $urandom_range(0, 2 * span) - span;
    endfunction

    task automatic queue_random_lines(input int count, input bit grazing);
        int sx, sy, sz, t;
        for (int k = 0; k < count; k++)
        begin
            sx = rand_coord(32768);
            sy = rand_coord(32768);
            sz = rand_coord(32768);
            if (grazing && $urandom_range(0, 3) != 0)
            begin
                // Nearly equal x and y steps: tiny denominator against the tilted plane.
                t = rand_coord(20000);
                queue_line(sx, sy, sz, sx + t, sy + t + rand_coord(3), rand_coord(32768));
            end
            else
                queue_line(sx, sy, sz, rand_coord(32768), rand_coord(32768),
                           rand_coord(32768));
        end
    endtask

    initial
    begin
        logic [31:0] floor_value;
        int span;
        error_count = 0;
        calm = 1'b0;
        hold_req = 1'b0;
        plane_a = '0;
        plane_b = '0;
        plane_c = '0;
        den_floor = 32'd1;
        cfg_we = 1'b0;
        cfg_index = REG_POINT_A;
        cfg_wdata = '0;
        ray_ch.start_x = '0;
        ray_ch.start_y = '0;
        ray_ch.start_z = '0;
        ray_ch.end_x = '0;
        ray_ch.end_y = '0;
        ray_ch.end_z = '0;
        rst_n = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Out of reset all plane points are zero, a degenerate plane: never a hit.
        queue_line(1, 2, 3, -4, 5, -6);
        queue_line(-32768, -32768, -32768, 32767, 32767, 32767);
        wait_drained();

        // Horizontal plane z = 0 with normal (0, 0, -10000).
        set_plane(pack_point(0, 0, 0), pack_point(100, 0, 0), pack_point(0, 100, 0), 1);
        queue_line(-32768, -32768, -32768, 32767, 32767, 32767);
        queue_line(32767, 32767, 32767, -32768, -32768, -32768);
        queue_line(32767, -32768, 32767, -32768, 32767, -32768);
        queue_line(5, 6, 7, 5, 6, 7);               // zero-length line
        queue_line(-32768, 100, 9, 32767, -200, 9); // parallel to the plane
        queue_line(10, 20, 0, 30, 40, 5);           // starts on the plane
        queue_line(0, 0, 1, 1, 3, -2);              // quotients truncate toward zero
        queue_line(0, 0, 1, -1, -3, -2);
        queue_line(0, 0, -1, -1, -3, 2);
        wait_drained();

        // A floor above every possible denominator leaves only misses.
        write_reg(REG_MIN_DEN, 48'hFFFF_FFFF);
        queue_line(-32768, -32768, -32768, 32767, 32767, 32767);
        queue_line(0, 0, 1, 1, 3, -2);
        wait_drained();

        // A zero floor still rejects a zero denominator.
        write_reg(REG_MIN_DEN, 48'd0);
        queue_line(5, 6, 7, 5, 6, 7);
        queue_line(0, 0, 1, 1, 3, -2);
        wait_drained();

        // Tilted plane with normal (1, -1, 0), met by lines whose denominator magnitude is 32768.
        set_plane(pack_point(0, 0, 0), pack_point(0, 0, 1), pack_point(1, 1, 0), 1);
        queue_line(-32768, 32767, 0, -1, 32766, 0);
        queue_line(32767, -32768, 0, 0, -32767, 0);
        queue_line(-32768, 32767, -32768, -1, 32766, 32767);
        wait_drained();

        // Random phases, each with a plane and floor of its own.
        for (int ph = 0; ph < 7; ph++)
        begin
            case (ph % 4)
                0: floor_value = 32'd0;
                1: floor_value = 32'd1;
                2: floor_value = $urandom_range(0, 1 << 20);
                default: floor_value = $urandom;
            endcase
            if (ph == 5)
                set_plane(pack_point(0, 0, 0), pack_point(0, 0, 1), pack_point(1, 1, 0),
                          floor_value);
            else
            begin
                span = (ph % 2 == 0) ? 32768 : 64;
                set_plane(pack_point(rand_coord(span), rand_coord(span), rand_coord(span)),
                          pack_point(rand_coord(span), rand_coord(span), rand_coord(span)),
                          pack_point(rand_coord(span), rand_coord(span), rand_coord(span)),
                          floor_value);
            end
            calm = (ph == 2);
            queue_random_lines(150, ph == 5);
            if (ph == 3)
                hold_req <= 1'b1;
            wait_drained();
        end

        if (error_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin
        #4ms;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

### files.f
rtl/core/lpi_pkg.sv
rtl/core/lpi_if.sv
rtl/core/lpi_front.sv
rtl/core/lpi_lane.sv
rtl/core/line_plane_intersection_core.sv
dv/testbench.sv
